// ===== design/c2s_pkg.sv =====
package c2s_pkg;

  // Widths of the item record that travels from front to back, and of the output count
  localparam int CENT_W = 16;
  localparam int DAYS_W = 16;
  localparam int SOD_W  = 17;
  localparam int OUT_W  = 48;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [6:0]  LAST_YEAR       = 7'd99;
  localparam logic [16:0] SECS_PER_DAY    = 17'd86400;
  localparam logic [31:0] SECS_PER_CENT   = 32'd3155760000;
  localparam logic [8:0]  DAYS_PER_YEAR   = 9'd365;
  localparam logic [11:0] SECS_PER_HOUR   = 12'd3600;
  localparam logic [5:0]  SECS_PER_MINUTE = 6'd60;

  // Days before the start of month index n (n = month - 1), normal year
  localparam logic [8:0] MONTH_START [13] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
    9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
  };

  typedef struct packed {
    logic [CENT_W-1:0] century;
    logic [DAYS_W-1:0] days;
    logic [SOD_W-1:0]  sod;
  } item_t;

  // Days in the months before month m; month zero adds none, above 12 saturates
  function automatic logic [8:0] days_before_month(input logic [3:0] m, input logic leap);
    logic [3:0] n;
    logic [8:0] d;
    n = (m == 4'd0) ? 4'd0 : m - 4'd1;
    if (n > 4'd12) begin
      n = 4'd12;
    end
    d = MONTH_START[n];
    if (leap && (n >= 4'd2)) begin
      d = d + 9'd1;
    end
    return d;
  endfunction

endpackage

// ===== design/c2s_queue.sv =====
module c2s_queue import c2s_pkg::*; #(
  parameter int Depth = QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  output logic  push_ready,
  input  item_t push_item,
  output logic  pop_valid,
  input  logic  pop_ready,
  output item_t pop_item
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  item_t           store [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            push;
  logic            pop;

  assign push_ready = (count != FullCnt);
  assign pop_valid  = (count != '0);
  assign pop_item   = store[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Write the entry
  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_item;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= FullCnt)
    else $error("queue occupancy above depth");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not advance on push");
  a_count_down: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> (count == $past(count) - 1'b1))
    else $error("queue count did not drop on pop");
`endif

endmodule

// ===== design/c2s_front.sv =====
module c2s_front import c2s_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [6:0] year_in_century,
  input  logic [3:0] month_number,
  input  logic [4:0] day_of_month,
  input  logic [4:0] hour_of_day,
  input  logic [5:0] minute_of_hour,
  input  logic [5:0] second_of_minute,
  output logic       push_valid,
  input  logic       push_ready,
  output item_t      push_item
);

  logic [6:0]        last_year_seen;
  logic [CENT_W-1:0] century_count;
  logic [CENT_W-1:0] century_count_next;
  logic              accept;
  logic              turn;
  logic              leap;
  logic [DAYS_W-1:0] year_days;
  logic [8:0]        month_days;
  logic [SOD_W-1:0]  sod;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign accept     = in_valid && push_ready;

  // Detect the century turn: a step from the last year straight to year zero
  assign turn = (last_year_seen == LAST_YEAR) && (year_in_century == 7'd0);
  assign century_count_next = turn ? century_count + 1'b1 : century_count;

  // Days of earlier years and earlier months
  assign leap       = (year_in_century[1:0] == 2'b00);
  assign year_days  = DAYS_W'(16'(year_in_century) * 16'(DAYS_PER_YEAR))
                    + DAYS_W'((8'(year_in_century) + 8'd3) >> 2);
  assign month_days = days_before_month(month_number, leap);

  // Seconds within the day
  assign sod = SOD_W'(17'(hour_of_day) * 17'(SECS_PER_HOUR))
             + SOD_W'(12'(minute_of_hour) * 12'(SECS_PER_MINUTE))
             + SOD_W'(second_of_minute);

  always_comb begin
    push_item.century = century_count_next;
    push_item.days    = year_days + DAYS_W'(month_days) + DAYS_W'(day_of_month);
    push_item.sod     = sod;
  end

  // Hold the last year and the century count between transactions
  always_ff @(posedge clk) begin
    if (rst) begin
      last_year_seen <= '0;
      century_count  <= '0;
    end else if (accept) begin
      last_year_seen <= year_in_century;
      century_count  <= century_count_next;
    end
  end

`ifndef SYNTH
  a_cent_turn: assert property (@(posedge clk) disable iff (rst)
    (accept && turn) |=> (century_count == $past(century_count) + 1'b1))
    else $error("century count missed a turn");
  a_cent_hold: assert property (@(posedge clk) disable iff (rst)
    !(accept && turn) |=> $stable(century_count))
    else $error("century count moved without a turn");
  a_year_track: assert property (@(posedge clk) disable iff (rst)
    accept |=> (last_year_seen == $past(year_in_century)))
    else $error("last year not captured");
`endif

endmodule

// ===== design/c2s_back.sv =====
module c2s_back import c2s_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  item_t            pop_item,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [OUT_W-1:0] seconds_count
);

  logic             s1_valid;
  logic [OUT_W-1:0] cent_secs;
  logic [32:0]      day_secs;
  logic [SOD_W-1:0] sod;
  logic             out_take;
  logic             s1_ready;

  assign out_take  = !out_valid || out_ready;
  assign s1_ready  = !s1_valid || out_take;
  assign pop_ready = s1_ready;

  // Stage valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= pop_valid;
      end
      if (out_take) begin
        out_valid <= s1_valid;
      end
    end
  end

  // Stage one: scale centuries and days to seconds
  always_ff @(posedge clk) begin
    if (pop_valid && s1_ready) begin
      cent_secs <= OUT_W'(pop_item.century) * OUT_W'(SECS_PER_CENT);
      day_secs  <= 33'(pop_item.days) * 33'(SECS_PER_DAY);
      sod       <= pop_item.sod;
    end
  end

  // Output stage: add the parts, hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (s1_valid && out_take) begin
      seconds_count <= cent_secs + OUT_W'(day_secs) + OUT_W'(sod);
    end
  end

`ifndef SYNTH
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !out_take) |=> (s1_valid && $stable(cent_secs) && $stable(day_secs)
                                 && $stable(sod)))
    else $error("stage one lost its transaction under stall");
  a_s1_load: assert property (@(posedge clk) disable iff (rst)
    (pop_valid && pop_ready) |=> s1_valid)
    else $error("popped transaction not in stage one");
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_take) |=> out_valid)
    else $error("stage one transaction not moved to output");
`endif

endmodule

// ===== design/calendar_to_seconds_count.sv =====
// Calendar reading to running seconds count.
// Input channel (in_valid / in_ready) takes one reading per transaction: year in
// century, month, day, hour, minute, second. Output channel (out_valid / out_ready)
// returns one seconds_count per reading, in order.
// The front converts a reading to a century count, a day count and seconds of day,
// and tracks the century turn (year 99 followed directly by year 0). A queue of
// QueueDepth entries sits between front and back. The back scales centuries and
// days to seconds in one register stage and adds the parts into the output register.
// An accepted reading goes into the queue, then stage one, then the output register.
// Throughput: one reading per cycle while the receiver is ready, set by the two-stage
// back end. When the receiver stalls, the output register and stage one hold, the
// queue fills, and in_ready drops once the queue is full; nothing is lost.
// Reset clears the century count, last year seen, queue, and both stage valid bits.
module calendar_to_seconds_count import c2s_pkg::*; #(
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [6:0]       year_in_century,
  input  logic [3:0]       month_number,
  input  logic [4:0]       day_of_month,
  input  logic [4:0]       hour_of_day,
  input  logic [5:0]       minute_of_hour,
  input  logic [5:0]       second_of_minute,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [OUT_W-1:0] seconds_count
);

  logic  push_valid;
  logic  push_ready;
  item_t push_item;
  logic  pop_valid;
  logic  pop_ready;
  item_t pop_item;

  c2s_front u_front (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .year_in_century  (year_in_century),
    .month_number     (month_number),
    .day_of_month     (day_of_month),
    .hour_of_day      (hour_of_day),
    .minute_of_hour   (minute_of_hour),
    .second_of_minute (second_of_minute),
    .push_valid       (push_valid),
    .push_ready       (push_ready),
    .push_item        (push_item)
  );

  c2s_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  c2s_back u_back (
    .clk           (clk),
    .rst           (rst),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_item      (pop_item),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .seconds_count (seconds_count)
  );

endmodule
